// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define RC5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RC5_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rc5_pkg.sv =====
`default_nettype none
package rc5_pkg;

  localparam int ROUNDS_MAX    = 32;
  localparam int KEY_BYTES_MAX = 64;
  localparam int TAB_DEPTH     = 2 * (ROUNDS_MAX + 1);
  localparam int TAB_AW        = $clog2(TAB_DEPTH);
  localparam int KW_DEPTH      = (KEY_BYTES_MAX + 3) / 4;
  localparam int KW_AW         = $clog2(KW_DEPTH);
  localparam int KLEN_W        = $clog2(KEY_BYTES_MAX + 1);
  localparam int C_W           = $clog2(KW_DEPTH + 1);
  localparam int PASS_W        = $clog2(3 * TAB_DEPTH + 1);
  localparam int RC_W          = 6;
  localparam int CFG_AW        = 3;

  localparam logic [31:0] MAGIC_P = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

  localparam logic [RC_W-1:0] RC_RESET = RC_W'(12);
  localparam logic [CFG_AW-3:0] REG_ROUNDS = '0;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_FIN = 2'd1,
    OP_ENC = 2'd2,
    OP_DEC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MIX_RD,
    ST_MIX_A,
    ST_MIX_B,
    ST_CRYPT_RD,
    ST_CRYPT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              append;
    logic              load_blk;
    logic              fin_start;
    logic              init_wr;
    logic              rd_en;
    logic              mix_a;
    logic              mix_b;
    logic              crypt_step;
    logic              dec;
    logic              fin;
    logic              out_load;
    logic [TAB_AW-1:0] idx;
    logic [TAB_AW-1:0] ra;
    logic [KW_AW-1:0]  j;
  } cmd_t;

  typedef struct packed {
    logic [C_W-1:0] c;
    logic           out_busy;
  } stat_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t rotr(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rc5_ram.sv =====
`default_nettype none
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rc5_ctrl.sv =====
`default_nettype none
module rc5_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  input  rc5_pkg::op_t                in_op,
  input  wire [rc5_pkg::RC_W-1:0]     rounds,
  input  rc5_pkg::stat_t              stat,
  output logic                        in_ready,
  output rc5_pkg::cmd_t               cmd
);

  rc5_pkg::state_t state_r, state_nxt;
  logic [rc5_pkg::TAB_AW-1:0] k_r, k_nxt;
  logic [rc5_pkg::KW_AW-1:0]  j_r, j_nxt;
  logic [rc5_pkg::PASS_W-1:0] pass_r, pass_nxt;
  logic                       fin_r, fin_nxt;
  logic                       dec_r, dec_nxt;

  logic [rc5_pkg::TAB_AW-1:0] t_cnt, last_idx, mx, i_next, first_idx;
  logic [rc5_pkg::PASS_W-1:0] pass_last;
  logic [rc5_pkg::KW_AW-1:0]  j_next;
  logic                       crypt_last, mix_last;

  // t = 2*(r+1), passes = 3*max(t,c)
  assign t_cnt     = rc5_pkg::TAB_AW'({rounds, 1'b0}) + rc5_pkg::TAB_AW'(2);
  assign last_idx  = t_cnt - rc5_pkg::TAB_AW'(1);
  assign mx        = (t_cnt >= rc5_pkg::TAB_AW'(stat.c)) ? t_cnt : rc5_pkg::TAB_AW'(stat.c);
  assign pass_last = rc5_pkg::PASS_W'({mx, 1'b0}) + rc5_pkg::PASS_W'(mx)
                     - rc5_pkg::PASS_W'(1);
  assign i_next    = (k_r == last_idx) ? '0 : k_r + rc5_pkg::TAB_AW'(1);
  assign j_next    = (rc5_pkg::C_W'(j_r) + rc5_pkg::C_W'(1) == stat.c) ? '0
                     : j_r + rc5_pkg::KW_AW'(1);
  assign first_idx = dec_r ? last_idx : '0;
  assign crypt_last = dec_r ? (k_r == '0) : (k_r == last_idx);
  assign mix_last   = (pass_r == pass_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc5_pkg::ST_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      pass_r  <= '0;
      fin_r   <= 1'b0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      pass_r  <= pass_nxt;
      fin_r   <= fin_nxt;
      dec_r   <= dec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc5_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            rc5_pkg::OP_FIN: state_nxt = rc5_pkg::ST_INIT;
            rc5_pkg::OP_ENC, rc5_pkg::OP_DEC: state_nxt = rc5_pkg::ST_CRYPT_RD;
            default: state_nxt = rc5_pkg::ST_IDLE;
          endcase
        end
      end
      rc5_pkg::ST_INIT: begin
        if (k_r == last_idx) begin
          state_nxt = rc5_pkg::ST_MIX_RD;
        end
      end
      rc5_pkg::ST_MIX_RD: state_nxt = rc5_pkg::ST_MIX_A;
      rc5_pkg::ST_MIX_A:  state_nxt = rc5_pkg::ST_MIX_B;
      rc5_pkg::ST_MIX_B:  state_nxt = mix_last ? rc5_pkg::ST_DONE : rc5_pkg::ST_MIX_A;
      rc5_pkg::ST_CRYPT_RD: state_nxt = rc5_pkg::ST_CRYPT;
      rc5_pkg::ST_CRYPT: begin
        if (crypt_last) begin
          state_nxt = rc5_pkg::ST_DONE;
        end
      end
      rc5_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = rc5_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rc5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.idx  = k_r;
    cmd.ra   = k_r;
    cmd.j    = j_r;
    cmd.dec  = dec_r;
    cmd.fin  = fin_r;
    case (state_r)
      rc5_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.append    = (in_op == rc5_pkg::OP_KEY);
          cmd.fin_start = (in_op == rc5_pkg::OP_FIN);
          cmd.load_blk  = (in_op == rc5_pkg::OP_ENC) || (in_op == rc5_pkg::OP_DEC);
        end
      end
      rc5_pkg::ST_INIT:   cmd.init_wr = 1'b1;
      rc5_pkg::ST_MIX_RD: cmd.rd_en   = 1'b1;
      rc5_pkg::ST_MIX_A:  cmd.mix_a   = 1'b1;
      rc5_pkg::ST_MIX_B: begin
        cmd.mix_b = 1'b1;
        cmd.rd_en = !mix_last;
        cmd.ra    = i_next;
      end
      rc5_pkg::ST_CRYPT_RD: begin
        cmd.rd_en = 1'b1;
        cmd.ra    = first_idx;
      end
      rc5_pkg::ST_CRYPT: begin
        cmd.crypt_step = 1'b1;
        cmd.rd_en      = !crypt_last;
        cmd.ra         = dec_r ? k_r - rc5_pkg::TAB_AW'(1) : k_r + rc5_pkg::TAB_AW'(1);
      end
      rc5_pkg::ST_DONE: cmd.out_load = !stat.out_busy;
      default: ;
    endcase
  end

  always_comb begin
    k_nxt    = k_r;
    j_nxt    = j_r;
    pass_nxt = pass_r;
    fin_nxt  = fin_r;
    dec_nxt  = dec_r;
    case (state_r)
      rc5_pkg::ST_IDLE: begin
        if (in_valid) begin
          fin_nxt  = (in_op == rc5_pkg::OP_FIN);
          dec_nxt  = (in_op == rc5_pkg::OP_DEC);
          k_nxt    = '0;
          j_nxt    = '0;
          pass_nxt = '0;
        end
      end
      rc5_pkg::ST_INIT: k_nxt = i_next;
      rc5_pkg::ST_MIX_B: begin
        k_nxt    = i_next;
        j_nxt    = j_next;
        pass_nxt = pass_r + rc5_pkg::PASS_W'(1);
      end
      rc5_pkg::ST_CRYPT_RD: k_nxt = first_idx;
      rc5_pkg::ST_CRYPT: begin
        if (!crypt_last) begin
          k_nxt = cmd.ra;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rc5_dp.sv =====
`default_nettype none
module rc5_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rc5_pkg::cmd_t        cmd,
  input  wire [7:0]            key_byte,
  input  wire [31:0]           blk_a,
  input  wire [31:0]           blk_b,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [31:0]          out_a,
  output logic [31:0]          out_b,
  output logic                 out_status,
  output rc5_pkg::stat_t       stat
);

  rc5_pkg::word_t a_r, a_nxt, b_r, b_nxt, val_r;
  rc5_pkg::word_t kw_r [rc5_pkg::KW_DEPTH];
  logic [rc5_pkg::KLEN_W-1:0] klen_r;
  logic                       trunc_r;
  logic [rc5_pkg::TAB_DEPTH-1:0] valid_r;
  logic                       rdv_r;
  logic                       out_valid_r;
  rc5_pkg::word_t out_a_r, out_b_r;
  logic                       out_status_r;

  rc5_pkg::word_t q, sdata, a_mix, ab, b_mix, wdata;
  logic           we, low_idx, odd_idx;

  assign we    = cmd.init_wr || cmd.mix_a;
  assign wdata = cmd.init_wr ? val_r : a_mix;

  rc5_ram #(
    .WIDTH(32),
    .DEPTH(rc5_pkg::TAB_DEPTH)
  ) u_tab (
    .clk  (clk),
    .we   (we),
    .waddr(cmd.idx),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(cmd.ra),
    .rdata(q)
  );

  // entries never written read as zero
  assign sdata = rdv_r ? q : '0;
  assign a_mix = rc5_pkg::rotl(sdata + a_r + b_r, 5'd3);
  assign ab    = a_r + b_r;
  assign b_mix = rc5_pkg::rotl(kw_r[cmd.j] + ab, ab[4:0]);

  assign low_idx = (cmd.idx[rc5_pkg::TAB_AW-1:1] == '0);
  assign odd_idx = cmd.idx[0];

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (cmd.load_blk) begin
      a_nxt = blk_a;
      b_nxt = blk_b;
    end else if (cmd.fin_start) begin
      a_nxt = '0;
      b_nxt = '0;
    end else if (cmd.mix_a) begin
      a_nxt = a_mix;
    end else if (cmd.mix_b) begin
      b_nxt = b_mix;
    end else if (cmd.crypt_step) begin
      if (!cmd.dec) begin
        if (low_idx && !odd_idx) begin
          a_nxt = a_r + sdata;
        end else if (low_idx) begin
          b_nxt = b_r + sdata;
        end else if (!odd_idx) begin
          a_nxt = rc5_pkg::rotl(a_r ^ b_r, b_r[4:0]) + sdata;
        end else begin
          b_nxt = rc5_pkg::rotl(b_r ^ a_r, a_r[4:0]) + sdata;
        end
      end else begin
        if (low_idx && !odd_idx) begin
          a_nxt = a_r - sdata;
        end else if (low_idx) begin
          b_nxt = b_r - sdata;
        end else if (!odd_idx) begin
          a_nxt = rc5_pkg::rotr(a_r - sdata, b_r[4:0]) ^ b_r;
        end else begin
          b_nxt = rc5_pkg::rotr(b_r - sdata, a_r[4:0]) ^ a_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (cmd.fin_start) begin
      val_r <= rc5_pkg::MAGIC_P;
    end else if (cmd.init_wr) begin
      val_r <= val_r + rc5_pkg::MAGIC_Q;
    end
    if (cmd.rd_en) begin
      rdv_r <= valid_r[cmd.ra];
    end
    if (cmd.out_load) begin
      out_a_r      <= cmd.fin ? '0 : a_r;
      out_b_r      <= cmd.fin ? '0 : b_r;
      out_status_r <= cmd.fin & trunc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[cmd.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < rc5_pkg::KW_DEPTH; n++) begin
        kw_r[n] <= '0;
      end
      klen_r  <= '0;
      trunc_r <= 1'b0;
    end else if (cmd.out_load && cmd.fin) begin
      // key store starts afresh after expansion
      for (int n = 0; n < rc5_pkg::KW_DEPTH; n++) begin
        kw_r[n] <= '0;
      end
      klen_r  <= '0;
      trunc_r <= 1'b0;
    end else if (cmd.mix_b) begin
      kw_r[cmd.j] <= b_mix;
    end else if (cmd.append) begin
      if (klen_r < rc5_pkg::KLEN_W'(rc5_pkg::KEY_BYTES_MAX)) begin
        kw_r[klen_r[rc5_pkg::KW_AW+1:2]] <= kw_r[klen_r[rc5_pkg::KW_AW+1:2]]
                                            | ({24'b0, key_byte} << {klen_r[1:0], 3'b000});
        klen_r <= klen_r + rc5_pkg::KLEN_W'(1);
      end else begin
        trunc_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.c        = (klen_r == '0) ? rc5_pkg::C_W'(1)
                         : rc5_pkg::C_W'((klen_r + rc5_pkg::KLEN_W'(3)) >> 2);
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

// ===== rtl/core/rc5_block_cipher_with_key_schedule.sv =====
// key byte: no result beat
// encrypt/decrypt: one sub-key table read per half round
// key finish: table init, then 3*max(t,c) mixing steps over the sub-key ram port
// one item at a time; a waiting result beat does not hold off the next accept
// rst_n is synchronous: round count back to 12, key store and table valid bits cleared
`default_nettype none
`include "assert_macros.svh"
module rc5_block_cipher_with_key_schedule (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [1:0]                   in_op,
  input  wire [7:0]                   in_key_byte,
  input  wire [31:0]                  in_word_a,
  input  wire [31:0]                  in_word_b,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [31:0]                 out_a,
  output logic [31:0]                 out_b,
  output logic                        out_status,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [rc5_pkg::CFG_AW-1:0]   paddr,
  input  wire [31:0]                  pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [rc5_pkg::RC_W-1:0] rc_r;
  logic [rc5_pkg::RC_W-1:0] rounds;
  logic                     hit;
  rc5_pkg::cmd_t            cmd;
  rc5_pkg::stat_t           stat;

  assign hit    = (paddr[rc5_pkg::CFG_AW-1:2] == rc5_pkg::REG_ROUNDS);
  assign pready = 1'b1;
  assign prdata = hit ? {{(32 - rc5_pkg::RC_W){1'b0}}, rc_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= rc5_pkg::RC_RESET;
    end else if (psel && penable && pwrite && hit) begin
      rc_r <= pwdata[rc5_pkg::RC_W-1:0];
    end
  end

  // saturate at the table size
  assign rounds = (rc_r > rc5_pkg::RC_W'(rc5_pkg::ROUNDS_MAX))
                  ? rc5_pkg::RC_W'(rc5_pkg::ROUNDS_MAX) : rc_r;

  rc5_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (rc5_pkg::op_t'(in_op)),
    .rounds  (rounds),
    .stat    (stat),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  rc5_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .key_byte  (in_key_byte),
    .blk_a     (in_word_a),
    .blk_b     (in_word_b),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_status(out_status),
    .stat      (stat)
  );

  `RC5_ASSERT(a_load_free, cmd.out_load |-> !(out_valid && !out_ready), "result overwritten")
  `RC5_ASSERT(a_fin_busy, (in_valid && in_ready && in_op == rc5_pkg::OP_FIN) |=> !in_ready, "accept during expansion")
  `RC5_ASSERT(a_port_clash, !(cmd.init_wr && cmd.rd_en), "table read during init")

endmodule
`default_nettype wire

// ===== test/rc5_block_cipher_with_key_schedule_tb.sv =====
`timescale 1ns / 100ps
module rc5_block_cipher_with_key_schedule_tb;
  import rc5_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [CFG_AW-1:0] ADDR_ROUNDS = {REG_ROUNDS, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE = 3'd4;

  typedef struct {
    word_t blk_a;
    word_t blk_b;
    logic  trunc;
  } block_result_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_op;
  logic [7:0] in_key_byte;
  logic [31:0] in_word_a, in_word_b;
  logic out_valid, out_ready;
  logic [31:0] out_a, out_b;
  logic out_status;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  rc5_block_cipher_with_key_schedule dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_key_byte(in_key_byte), .in_word_a(in_word_a), .in_word_b(in_word_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_a(out_a), .out_b(out_b),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow of the cipher state
  logic [5:0] rounds_reg;
  word_t sub_keys[TAB_DEPTH];
  word_t key_store[KW_DEPTH];
  int key_len;
  logic key_dropped;

  block_result_t cipher_results_q[$];
  int errors;
  int items_sent;
  bit calm_sender, calm_receiver;
  int hold_request;

  function automatic word_t rot_left(word_t x, word_t n);
    int s;
    s = n[4:0];
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic word_t rot_right(word_t x, word_t n);
    int s;
    s = n[4:0];
    if (s == 0) return x;
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic int live_rounds();
    return (rounds_reg > ROUNDS_MAX) ? ROUNDS_MAX : int'(rounds_reg);
  endfunction

  function automatic void clear_state();
    rounds_reg = RC_RESET;
    foreach (sub_keys[k]) sub_keys[k] = '0;
    foreach (key_store[k]) key_store[k] = '0;
    key_len = 0;
    key_dropped = 1'b0;
  endfunction

  function automatic void expand_schedule();
    int t, c, passes, i, j;
    word_t a, b;
    t = 2 * (live_rounds() + 1);
    c = (key_len == 0) ? 1 : (key_len + 3) / 4;
    passes = 3 * ((t > c) ? t : c);
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    sub_keys[0] = MAGIC_P;
    for (int k = 1; k < t; k++) sub_keys[k] = sub_keys[k-1] + MAGIC_Q;
    for (int k = 0; k < passes; k++) begin
      a = rot_left(sub_keys[i] + a + b, 3);
      sub_keys[i] = a;
      b = rot_left(key_store[j] + a + b, a + b);
      key_store[j] = b;
      i = (i + 1 == t) ? 0 : i + 1;
      j = (j + 1 == c) ? 0 : j + 1;
    end
  endfunction

  // works out what one accepted beat produces and queues any result beat
  function automatic void rc5_apply(op_t op, logic [7:0] kb, word_t wa, word_t wb);
    block_result_t res;
    int r;
    r = live_rounds();
    res.trunc = 1'b0;
    case (op)
      OP_KEY: begin
        if (key_len < KEY_BYTES_MAX) begin
          key_store[key_len / 4] |= word_t'(kb) << (8 * (key_len % 4));
          key_len++;
        end else begin
          key_dropped = 1'b1;
        end
        return;
      end
      OP_FIN: begin
        expand_schedule();
        res.blk_a = '0;
        res.blk_b = '0;
        res.trunc = key_dropped;
        foreach (key_store[k]) key_store[k] = '0;
        key_len = 0;
        key_dropped = 1'b0;
      end
      OP_ENC: begin
        wa += sub_keys[0];
        wb += sub_keys[1];
        for (int i = 1; i <= r; i++) begin
          wa = rot_left(wa ^ wb, wb) + sub_keys[2*i];
          wb = rot_left(wb ^ wa, wa) + sub_keys[2*i+1];
        end
        res.blk_a = wa;
        res.blk_b = wb;
      end
      default: begin
        for (int i = r; i > 0; i--) begin
          wb = rot_right(wb - sub_keys[2*i+1], wa) ^ wa;
          wa = rot_right(wa - sub_keys[2*i], wb) ^ wb;
        end
        res.blk_b = wb - sub_keys[1];
        res.blk_a = wa - sub_keys[0];
      end
    endcase
    cipher_results_q.push_back(res);
  endfunction

  task automatic send_item(op_t op, logic [7:0] kb, word_t wa, word_t wb);
    int gap, pick;
    gap = 0;
    if (!calm_sender) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(10, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key_byte <= kb;
    in_word_a <= wa;
    in_word_b <= wb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rc5_apply(op, kb, wa, wb);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (cipher_results_q.size() == 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ROUNDS) rounds_reg = value[5:0];
  endtask

  task automatic set_rounds(int r);
    settle();
    write_reg(ADDR_ROUNDS, r);
  endtask

  task automatic load_key(int len);
    for (int k = 0; k < len; k++) send_item(OP_KEY, $urandom_range(0, 255), $urandom, $urandom);
    send_item(OP_FIN, $urandom_range(0, 255), $urandom, $urandom);
  endtask

  task automatic test_unkeyed_table();
    send_item(OP_ENC, 8'h00, 32'h0, 32'h0);
    send_item(OP_ENC, 8'h00, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_DEC, 8'h00, 32'h1234_5678, 32'h9abc_def0);
  endtask

  task automatic test_basic_key();
    send_item(OP_KEY, 8'h00, 32'h0, 32'h0);
    send_item(OP_KEY, 8'hff, 32'h0, 32'h0);
    send_item(OP_KEY, 8'ha5, 32'h0, 32'h0);
    send_item(OP_KEY, 8'h5a, 32'h0, 32'h0);
    send_item(OP_KEY, 8'h01, 32'h0, 32'h0);
    send_item(OP_FIN, 8'h00, 32'h0, 32'h0);
    send_item(OP_ENC, 8'h00, 32'h0, 32'h0);
    send_item(OP_ENC, 8'h00, 32'hffff_ffff, 32'h0);
    send_item(OP_DEC, 8'h00, 32'h0, 32'hffff_ffff);
    send_item(OP_DEC, 8'h00, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_empty_key();
    send_item(OP_FIN, 8'h00, 32'h0, 32'h0);
    send_item(OP_ENC, 8'h00, 32'hdead_beef, 32'h0bad_f00d);
  endtask

  task automatic test_key_overflow();
    load_key(KEY_BYTES_MAX + 6);
    send_item(OP_ENC, 8'h00, $urandom, $urandom);
    load_key(KEY_BYTES_MAX);
    send_item(OP_DEC, 8'h00, $urandom, $urandom);
  endtask

  task automatic test_round_extremes();
    set_rounds(0);
    load_key(3);
    send_item(OP_ENC, 8'h00, $urandom, $urandom);
    send_item(OP_DEC, 8'h00, $urandom, $urandom);
    set_rounds(ROUNDS_MAX);
    load_key(16);
    send_item(OP_ENC, 8'h00, $urandom, $urandom);
    set_rounds(63);
    load_key(8);
    send_item(OP_DEC, 8'h00, $urandom, $urandom);
    // shorter round count over a table built for more rounds
    set_rounds(5);
    send_item(OP_ENC, 8'h00, $urandom, $urandom);
    settle();
    write_reg(ADDR_SPARE, 32'h1);
    send_item(OP_DEC, 8'h00, $urandom, $urandom);
  endtask

  task automatic test_backpressure();
    settle();
    calm_sender = 1'b1;
    hold_request = 300;
    for (int k = 0; k < 20; k++) send_item(OP_ENC, 8'h00, $urandom, $urandom);
    calm_sender = 1'b0;
    // pause until everything has drained
    settle();
    send_item(OP_DEC, 8'h00, $urandom, $urandom);
  endtask

  task automatic test_random_traffic();
    int pick, len;
    while (items_sent < 620) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        pick = $urandom_range(0, 9);
        set_rounds(pick < 6 ? $urandom_range(0, 16) : $urandom_range(0, 63));
      end
      calm_sender = ($urandom_range(0, 9) == 0);
      calm_receiver = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        for (int k = 0; k < 6; k++)
          send_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom, $urandom);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 20);
        load_key(len);
        len = $urandom_range(3, 10);
        for (int k = 0; k < len; k++)
          send_item($urandom_range(0, 1) ? OP_ENC : OP_DEC, $urandom_range(0, 255),
                    $urandom, $urandom);
      end
    end
    calm_sender = 1'b0;
    calm_receiver = 1'b0;
  endtask

  // result side ready, with its own long hold-off when asked
  int hold_left;
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (calm_receiver || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    block_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_results_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: a=%h b=%h status=%b",
                 $realtime, out_a, out_b, out_status);
        errors++;
      end else begin
        want = cipher_results_q.pop_front();
        if (out_a !== want.blk_a) begin
          $display("%0t: out_a expected %h actual %h", $realtime, want.blk_a, out_a);
          errors++;
        end
        if (out_b !== want.blk_b) begin
          $display("%0t: out_b expected %h actual %h", $realtime, want.blk_b, out_b);
          errors++;
        end
        if (out_status !== want.trunc) begin
          $display("%0t: out_status expected %b actual %b", $realtime, want.trunc,
                   out_status);
          errors++;
        end
      end
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    calm_sender = 1'b0;
    calm_receiver = 1'b0;
    hold_request = 0;
    hold_left = 0;
    idle_cycles = 0;
    clear_state();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_KEY;
    in_key_byte <= '0;
    in_word_a <= '0;
    in_word_b <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unkeyed_table();
    test_basic_key();
    test_empty_key();
    test_key_overflow();
    test_round_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
